// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character codes and the alphabet lookup for the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   // job queue between front end and back end
   localparam int unsigned QDepth = 2;
   localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int unsigned QCntW  = $clog2(QDepth + 1);

   localparam logic [7:0] CharPad   = 8'h3D;  // '='
   localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
   localparam logic [7:0] CharSlash = 8'h2F;  // '/'
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharLoA   = 8'h61;
   localparam logic [7:0] CharLoZ   = 8'h7A;
   localparam logic [7:0] CharDig0  = 8'h30;
   localparam logic [7:0] CharDig9  = 8'h39;

   // one held character of the current group
   typedef struct packed {
      logic       is_pad;
      logic [5:0] value;
   } b64d_entry_type;

   // work handed from front end to back end: count results, 1 to 3
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            is_error;
   } b64d_job_type;

   function automatic logic [5:0] sixbit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CharUpA && c <= CharUpZ) begin
         d = c - CharUpA;
      end else if (c >= CharLoA && c <= CharLoZ) begin
         d = c - CharLoA + 8'd26;
      end else if (c >= CharDig0 && c <= CharDig9) begin
         d = c - CharDig0 + 8'd52;
      end else if (c == CharPlus) begin
         d = 8'd62;
      end else if (c == CharSlash) begin
         d = 8'd63;
      end
      return d[5:0];
   endfunction

endpackage

// ----- rtl/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the current group and the stream state, and
// turns each request into at most one job for the back end.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         q_full,
   output logic         push_valid,
   output b64d_job_type push_job
);

   b64d_entry_type group_ff [3];
   logic [1:0]     count_ff, count_in;
   logic           end_seen_ff, end_seen_in;
   logic           err_rep_ff, err_rep_in;

   logic           accept;
   logic [7:0]     c;
   logic           is_ws, is_pad, prev_pad;
   logic           raise, store_en, make_data, err_job;
   b64d_entry_type entry_now;
   logic [5:0]     w, x, y, z;
   logic [1:0]     n;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign is_ws      = (c == CharSpace) || (c == CharTab) || (c == CharCr) || (c == CharLf);
   assign is_pad     = (c == CharPad);
   assign entry_now  = '{is_pad: is_pad, value: sixbit_of(c)};

   always_comb begin
      case (count_ff)
         2'd1:    prev_pad = group_ff[0].is_pad;
         2'd2:    prev_pad = group_ff[1].is_pad;
         2'd3:    prev_pad = group_ff[2].is_pad;
         default: prev_pad = 1'b0;
      endcase
   end

   always_comb begin
      raise     = 1'b0;
      store_en  = 1'b0;
      make_data = 1'b0;
      if (req_tuser) begin
         raise = (count_ff != 2'd0);
      end else if (is_ws) begin
         raise = 1'b0;
      end else if (end_seen_ff) begin
         raise = 1'b1;
      end else if (prev_pad && !is_pad) begin
         raise = 1'b1;
      end else if (count_ff != 2'd3) begin
         store_en = 1'b1;
      end else begin
         make_data = 1'b1;
      end
   end

   assign err_job = raise && !err_rep_ff;

   assign w = group_ff[0].value;
   assign x = group_ff[1].value;
   assign y = group_ff[2].value;
   assign z = entry_now.value;
   assign n = 2'd1 + {1'b0, !group_ff[2].is_pad} + {1'b0, !is_pad};

   always_comb begin
      push_job = '0;
      if (err_job) begin
         push_job.count    = 2'd1;
         push_job.is_error = 1'b1;
      end else begin
         push_job.data[0] = {w, x[5:4]};
         push_job.data[1] = {x[3:0], y[5:2]};
         push_job.data[2] = {y[1:0], z};
         push_job.count   = n;
      end
   end

   assign push_valid = accept && (err_job || make_data);

   always_comb begin
      count_in    = count_ff;
      end_seen_in = end_seen_ff;
      err_rep_in  = err_rep_ff;
      if (accept) begin
         if (err_job) begin
            err_rep_in = 1'b1;
         end
         if (store_en) begin
            count_in = count_ff + 2'd1;
         end
         if (make_data) begin
            count_in = 2'd0;
            if (is_pad) begin
               end_seen_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 2'd0;
         end_seen_ff <= 1'b0;
         err_rep_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         end_seen_ff <= end_seen_in;
         err_rep_ff  <= err_rep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_en) begin
         group_ff[count_ff] <= entry_now;
      end
   end

`ifndef SYNTHESIS
   // the error report is one-shot
   a_err_once: assert property (@(posedge clock) disable iff (reset)
      err_rep_ff |-> !(push_valid && push_job.is_error))
      else $error("second error job pushed");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_rep_ff |=> err_rep_ff)
      else $error("error flag cleared");

   a_end_no_data: assert property (@(posedge clock) disable iff (reset)
      end_seen_ff |-> !(push_valid && !push_job.is_error))
      else $error("data after end of stream");
`endif

endmodule

// ----- rtl/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Short register queue of decoded jobs between front end and back end.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64d_job_type push_job,
   input  logic         pop,
   output logic         full,
   output logic         head_valid,
   output b64d_job_type head_job
);

   b64d_job_type     slot_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == QCntW'(QDepth));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntW'(QDepth))
      else $error("queue count overflow");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_job.count != 2'd0))
      else $error("queued job with no results");
`endif

endmodule

// ----- rtl/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Walks the job at the head of the queue and presents its results one per
// cycle on the response stream while rsp_tready is high.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  b64d_job_type head_job,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic [0:0]   rsp_tuser,
   output logic         rsp_tlast
);

   logic [1:0] idx_ff, idx_in;
   logic       fire;

   assign rsp_tvalid = head_valid;
   assign rsp_tuser  = head_job.is_error;
   assign rsp_tlast  = ((idx_ff + 2'd1) == head_job.count);
   assign fire       = rsp_tvalid && rsp_tready;
   assign pop        = fire && rsp_tlast;

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_tdata = head_job.data[0];
         2'd1:    rsp_tdata = head_job.data[1];
         2'd2:    rsp_tdata = head_job.data[2];
         default: rsp_tdata = 8'd0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = rsp_tlast ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (idx_ff < head_job.count))
      else $error("result index past job size");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("error report not a single zero result");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == 2'd0))
      else $error("stale result index");
`endif

endmodule

// ----- rtl/base64_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 decoder taking one character per request, producing decoded bytes.
// ----------------------------------------------------------------------------
// One character (or an end-of-stream mark in req_tuser) is taken per cycle
// while the two-entry job queue has room. The front end classifies the
// character and updates the group in the same cycle; a completed group or an
// error report becomes one job. The back end emits one result per cycle
// while rsp_tready is high, three for a full group; a queued job's first
// result appears once it reaches the queue head. Since four characters give
// at most three bytes, a continuous stream runs at one character per cycle as
// long as the response side keeps up. The last result of each job has
// rsp_tlast set; the single error report has rsp_tuser set and zero data.
module base64_stream_decoder_unit import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic [0:0] req_tuser,   // [0] end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [0:0] rsp_tuser,   // [0] is_error
   output logic       rsp_tlast
);

   logic         push_valid, q_full, pop, head_valid;
   b64d_job_type push_job, head_job;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser[0]),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
